// ===== hw/rtl/rc4_pkg.sv =====
// ============================================================================
// rc4_pkg
// Shared constants, state encoding and controller/datapath command types.
// ============================================================================
package rc4_pkg;

    localparam int BYTE_W          = 8;
    localparam int PERM_DEPTH      = 256;
    localparam int PERM_ADDR_W     = 8;
    localparam int KEY_STORE_DEPTH = 256;
    localparam int KEY_ADDR_W      = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
    localparam int KEY_CNT_W       = $clog2(KEY_STORE_DEPTH + 1);

    // item kinds carried on tuser
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_D_RDJ,
        ST_D_SWP,
        ST_D_OUT,
        ST_K_RDS,
        ST_K_RDJ,
        ST_K_WRN,
        ST_K_WRJ
    } rc4_state_t;

    // permutation read address source
    typedef enum logic [1:0] {
        RA_I_NEXT,
        RA_J_SUM,
        RA_T_SUM,
        RA_N
    } rc4_raddr_t;

    // permutation write address source
    typedef enum logic [1:0] {
        WA_I,
        WA_N,
        WA_J
    } rc4_waddr_t;

    typedef struct packed {
        logic       key_load;
        logic       data_load;
        logic       ks_start;
        logic       perm_re;
        rc4_raddr_t perm_raddr;
        logic       perm_we;
        rc4_waddr_t perm_waddr;
        logic       key_re;
        logic       j_load;
        logic       use_key;
        logic       t_load;
        logic       out_load;
        logic       ks_step;
        logic       ks_finish;
    } rc4_cmd_t;

    typedef struct packed {
        logic out_free;
        logic n_last;
    } rc4_stat_t;

endpackage

// ===== hw/rtl/rc4_ram.sv =====
// ============================================================================
// rc4_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rc4_ctrl.sv =====
// ============================================================================
// rc4_ctrl
// Sequencer for key loading, key schedule and per-byte keystream steps.
// ============================================================================
module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      s_tuser,
    input  logic      s_tlast,
    input  rc4_stat_t stat,
    output rc4_cmd_t  cmd
);

    rc4_state_t state_reg;
    rc4_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.perm_raddr = RA_I_NEXT;
        cmd.perm_waddr = WA_J;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                // keep S[i+1] fetched for the next data byte
                cmd.perm_re    = 1'b1;
                cmd.perm_raddr = RA_I_NEXT;
                if (s_tvalid) begin
                    if (s_tuser == MODE_DATA) begin
                        cmd.data_load = 1'b1;
                        state_next    = ST_D_RDJ;
                    end else begin
                        cmd.key_load = 1'b1;
                        if (s_tlast) begin
                            cmd.ks_start = 1'b1;
                            state_next   = ST_K_RDS;
                        end
                    end
                end
            end
            ST_D_RDJ: begin
                cmd.perm_re    = 1'b1;
                cmd.perm_raddr = RA_J_SUM;
                cmd.j_load     = 1'b1;
                state_next     = ST_D_SWP;
            end
            ST_D_SWP: begin
                cmd.perm_re    = 1'b1;
                cmd.perm_raddr = RA_T_SUM;
                cmd.perm_we    = 1'b1;
                cmd.perm_waddr = WA_I;
                cmd.t_load     = 1'b1;
                state_next     = ST_D_OUT;
            end
            ST_D_OUT: begin
                cmd.perm_we    = 1'b1;
                cmd.perm_waddr = WA_J;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_K_RDS: begin
                cmd.perm_re    = 1'b1;
                cmd.perm_raddr = RA_N;
                cmd.key_re     = 1'b1;
                state_next     = ST_K_RDJ;
            end
            ST_K_RDJ: begin
                cmd.perm_re    = 1'b1;
                cmd.perm_raddr = RA_J_SUM;
                cmd.j_load     = 1'b1;
                cmd.use_key    = 1'b1;
                state_next     = ST_K_WRN;
            end
            ST_K_WRN: begin
                cmd.perm_we    = 1'b1;
                cmd.perm_waddr = WA_N;
                state_next     = ST_K_WRJ;
            end
            ST_K_WRJ: begin
                cmd.perm_we    = 1'b1;
                cmd.perm_waddr = WA_J;
                cmd.ks_step    = 1'b1;
                if (stat.n_last) begin
                    cmd.ks_finish = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    state_next    = ST_K_RDS;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a final key byte always enters the key schedule
    a_last_key_starts_schedule: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == MODE_KEY) && s_tlast) |=> (state_reg == ST_K_RDS))
        else $error("final key byte did not start the key schedule");

endmodule

// ===== hw/rtl/rc4_dp.sv =====
// ============================================================================
// rc4_dp
// Permutation and key stores, generator indices and output register.
// ============================================================================
module rc4_dp
    import rc4_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BYTE_W-1:0] s_tdata,
    input  rc4_cmd_t          cmd,
    output rc4_stat_t         stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata
);

    logic [PERM_ADDR_W-1:0] i_reg, i_next;
    logic [PERM_ADDR_W-1:0] j_reg, j_next;
    logic [PERM_ADDR_W-1:0] n_reg, n_next;
    logic [KEY_ADDR_W-1:0]  k_reg, k_next;
    logic [KEY_CNT_W-1:0]   key_cnt_reg, key_cnt_next;
    logic [PERM_DEPTH-1:0]  vld_reg, vld_next;
    logic                   vld_q_reg, vld_q_next;
    logic [PERM_ADDR_W-1:0] raddr_q_reg, raddr_q_next;
    logic                   out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0] si_reg, si_next;
    logic [BYTE_W-1:0] sj_reg, sj_next;
    logic [BYTE_W-1:0] t_reg, t_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;

    logic [PERM_ADDR_W-1:0] perm_raddr;
    logic [PERM_ADDR_W-1:0] perm_waddr;
    logic [BYTE_W-1:0]      perm_wdata;
    logic [BYTE_W-1:0]      perm_q;
    logic [BYTE_W-1:0]      rd;
    logic [BYTE_W-1:0]      key_q;
    logic [BYTE_W-1:0]      j_sum;
    logic [BYTE_W-1:0]      ks_byte;
    logic [KEY_ADDR_W:0]    k_inc;
    logic                   key_full;
    logic                   key_we;

    // entries never written since the last schedule read as identity
    assign rd       = vld_q_reg ? perm_q : raddr_q_reg;
    assign j_sum    = j_reg + rd + (cmd.use_key ? key_q : {BYTE_W{1'b0}});
    assign key_full = (key_cnt_reg == KEY_CNT_W'(KEY_STORE_DEPTH));
    assign key_we   = cmd.key_load && !key_full;
    assign k_inc    = {1'b0, k_reg} + {{KEY_ADDR_W{1'b0}}, 1'b1};

    always_comb begin
        case (cmd.perm_raddr)
            RA_I_NEXT: perm_raddr = i_reg + 8'd1;
            RA_J_SUM:  perm_raddr = j_sum;
            RA_T_SUM:  perm_raddr = si_reg + rd;
            RA_N:      perm_raddr = n_reg;
            default:   perm_raddr = n_reg;
        endcase
    end

    always_comb begin
        case (cmd.perm_waddr)
            WA_I:    perm_waddr = i_reg;
            WA_N:    perm_waddr = n_reg;
            WA_J:    perm_waddr = j_reg;
            default: perm_waddr = j_reg;
        endcase
        perm_wdata = (cmd.perm_waddr == WA_J) ? si_reg : rd;
    end

    // keystream byte, corrected for the swap still in flight at its read
    always_comb begin
        if (t_reg == i_reg) begin
            ks_byte = sj_reg;
        end else if (t_reg == j_reg) begin
            ks_byte = si_reg;
        end else begin
            ks_byte = rd;
        end
    end

    always_comb begin
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        key_cnt_next   = key_cnt_reg;
        vld_next       = vld_reg;
        vld_q_next     = vld_q_reg;
        raddr_q_next   = raddr_q_reg;
        out_valid_next = out_valid_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        t_next         = t_reg;
        data_next      = data_reg;
        out_data_next  = out_data_reg;

        if (cmd.data_load) begin
            i_next    = i_reg + 8'd1;
            data_next = s_tdata;
        end
        if (key_we) begin
            key_cnt_next = key_cnt_reg + KEY_CNT_W'(1);
        end
        if (cmd.ks_start) begin
            j_next   = '0;
            n_next   = '0;
            k_next   = '0;
            vld_next = '0;
        end
        if (cmd.j_load) begin
            j_next  = j_sum;
            si_next = rd;
        end
        if (cmd.t_load) begin
            sj_next = rd;
            t_next  = si_reg + rd;
        end
        if (cmd.perm_re) begin
            vld_q_next   = vld_reg[perm_raddr];
            raddr_q_next = perm_raddr;
        end
        if (cmd.perm_we) begin
            vld_next[perm_waddr] = 1'b1;
        end
        if (cmd.ks_step) begin
            n_next = n_reg + 8'd1;
            if (k_inc >= (KEY_ADDR_W + 1)'(key_cnt_reg)) begin
                k_next = '0;
            end else begin
                k_next = k_inc[KEY_ADDR_W-1:0];
            end
        end
        if (cmd.ks_finish) begin
            i_next       = '0;
            j_next       = '0;
            key_cnt_next = '0;
        end
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = data_reg ^ ks_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            key_cnt_reg   <= '0;
            vld_reg       <= '0;
            vld_q_reg     <= 1'b0;
            raddr_q_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            key_cnt_reg   <= key_cnt_next;
            vld_reg       <= vld_next;
            vld_q_reg     <= vld_q_next;
            raddr_q_reg   <= raddr_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        t_reg        <= t_next;
        data_reg     <= data_next;
        out_data_reg <= out_data_next;
    end

    rc4_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(PERM_DEPTH)
    ) u_perm_ram (
        .aclk  (aclk),
        .we    (cmd.perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .re    (cmd.perm_re),
        .raddr (perm_raddr),
        .rdata (perm_q)
    );

    rc4_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(KEY_STORE_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_cnt_reg[KEY_ADDR_W-1:0]),
        .wdata (s_tdata),
        .re    (cmd.key_re),
        .raddr (k_reg),
        .rdata (key_q)
    );

    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.n_last   = (n_reg == 8'hFF);
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result loaded over an untaken result");

    a_sched_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ks_finish |=> (i_reg == '0 && j_reg == '0 && key_cnt_reg == '0))
        else $error("indices or key count not cleared after key schedule");

    a_i_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.data_load |=> (i_reg == $past(i_reg) + 8'd1))
        else $error("index i did not advance on a data byte");

endmodule

// ===== hw/rtl/rc4_stream_cipher.sv =====
// ============================================================================
// rc4_stream_cipher
// RC4 byte stream cipher with a loadable key, stream in and stream out.
// ============================================================================
// Key bytes (s_tuser = 0) are stored one per transaction; up to 256 are kept
// and further ones are dropped. The transaction with s_tlast high on a key
// byte starts the key schedule, which resets the permutation to identity
// and runs 256 swap steps, so the input is not ready until the schedule is
// done; the key store then starts over for the next key. Key bytes give no
// output. A data byte (s_tuser = 1) is XORed with the next keystream byte
// and returned on the m_ side; encryption and decryption are the same
// operation. A data byte is worked through these steps in turn, an order
// set by the permutation RAM with its single read port and single write
// port: S[j] read, swap write of S[i] with the keystream read, swap write
// of S[j], and the idle cycle in which S[i+1] is fetched and the byte is
// taken. A result sits in an output register, so the next byte is taken and
// worked on while it waits; that byte is then held in its last cycle until
// the register is free, and the input is not ready meanwhile.
// After reset the permutation is the identity and both indices are zero.
// ============================================================================
module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte (key byte or data byte)
    input  logic              s_tuser,   // [0] mode: 0 key byte, 1 data byte
    input  logic              s_tlast,   // final key byte, starts the key schedule
    // result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata    // [7:0] out_byte
);

    // command and status between sequencer and datapath
    rc4_cmd_t  cmd;
    rc4_stat_t stat;

    // sequencer: accepts each transaction and steps the swap sequences
    rc4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: permutation RAM, key RAM, indices and output register
    rc4_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== tb/rc4_stream_cipher_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rc4_stream_cipher_checker
// Watches both stream channels of the cipher and keeps its own copy of the
// key store, permutation and generator indices. Every accepted data byte
// queues the byte it must come back as. Every result transaction is compared
// with the oldest queued byte. The error and outstanding counts go to the
// testbench top.
// ============================================================================
module rc4_stream_cipher_checker
    import rc4_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic              s_tuser,   // [0] mode
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output int unsigned       fail_count,
    output int unsigned       outstanding_bytes
);

    logic [BYTE_W-1:0]    perm_s [PERM_DEPTH];
    logic [BYTE_W-1:0]    key_bytes [KEY_STORE_DEPTH];
    logic [KEY_CNT_W-1:0] key_len;
    logic [BYTE_W-1:0]    gen_i;
    logic [BYTE_W-1:0]    gen_j;
    logic [BYTE_W-1:0]    crypted_bytes_due [$];
    int unsigned          error_count = 0;
    int unsigned          results_seen = 0;

    task automatic swap_perm(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] t;
        t         = perm_s[a];
        perm_s[a] = perm_s[b];
        perm_s[b] = t;
    endtask

    always @(posedge aclk) begin : track
        logic [BYTE_W-1:0] sched_j;
        logic [BYTE_W-1:0] ks_addr;
        logic [BYTE_W-1:0] want;
        logic [BYTE_W-1:0] crypted;
        int                n;
        int                k;
        if (!aresetn) begin
            for (n = 0; n < PERM_DEPTH; n++) perm_s[n] = n[BYTE_W-1:0];
            key_len = '0;
            gen_i   = '0;
            gen_j   = '0;
            crypted_bytes_due.delete();
        end else begin
            // result side first: a byte accepted at this edge cannot leave at it
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (crypted_bytes_due.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result %0d: out_byte %02h with nothing expected",
                                 results_seen, m_tdata);
                end else begin
                    want = crypted_bytes_due.pop_front();
                    if (m_tdata !== want) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("result %0d: out_byte expected %02h, got %02h",
                                     results_seen, want, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == MODE_KEY) begin
                    // bytes past the store depth are dropped
                    if (key_len < KEY_STORE_DEPTH) begin
                        key_bytes[key_len] = s_tdata;
                        key_len++;
                    end
                    // flagged byte: full key schedule, then a fresh key store
                    if (s_tlast) begin
                        for (n = 0; n < PERM_DEPTH; n++) perm_s[n] = n[BYTE_W-1:0];
                        sched_j = '0;
                        k       = 0;
                        for (n = 0; n < PERM_DEPTH; n++) begin
                            sched_j = sched_j + perm_s[n] + key_bytes[k];
                            swap_perm(n[BYTE_W-1:0], sched_j);
                            k++;
                            if (k >= key_len) k = 0;
                        end
                        gen_i   = '0;
                        gen_j   = '0;
                        key_len = '0;
                    end
                end else begin
                    // tlast means nothing on a data byte
                    gen_i = gen_i + 1'b1;
                    gen_j = gen_j + perm_s[gen_i];
                    swap_perm(gen_i, gen_j);
                    ks_addr = perm_s[gen_i] + perm_s[gen_j];
                    crypted = s_tdata ^ perm_s[ks_addr];
                    crypted_bytes_due = {crypted_bytes_due, crypted};
                end
            end
        end
        fail_count        <= error_count;
        outstanding_bytes <= crypted_bytes_due.size();
    end

endmodule

// ===== tb/rc4_stream_cipher_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rc4_stream_cipher_test
// Drives key loads and data bytes into the cipher under three idle patterns
// and hands the checking to rc4_stream_cipher_checker. Directed bytes cover
// data before any key, one-byte and short keys, a key split by data, a flag
// on data, and keys at and past the store depth. Random traffic follows.
// ============================================================================
module rc4_stream_cipher_test
    import rc4_pkg::*;
();

    localparam int RX_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES    = 1100;  // covers a key schedule still running

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic              s_tuser  = MODE_KEY;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;

    int unsigned       fail_count;
    int unsigned       outstanding_bytes;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    bit                rx_hold_req   = 1'b0;

    always #5 aclk = ~aclk;

    rc4_stream_cipher DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rc4_stream_cipher_checker u_crypt_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .s_tlast           (s_tlast),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .fail_count        (fail_count),
        .outstanding_bytes (outstanding_bytes)
    );

    // one input transaction, after a random number of idle cycles
    task automatic send_item(input logic mode, input logic [BYTE_W-1:0] b,
                             input logic flag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        s_tlast  <= flag;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic load_key(input int unsigned len);
        int unsigned n;
        for (n = 0; n < len; n++)
            send_item(MODE_KEY, BYTE_W'($urandom_range(255)), n == len - 1);
    endtask

    // sender stops until every crypted byte has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding_bytes != 0) @(posedge aclk);
    endtask

    // mostly data, now and then a full key load, a few stray key bytes
    task automatic random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned pick;
        int unsigned len;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(999);
            if (pick < 20) begin
                len = (pick < 2) ? $urandom_range(250, 262) : $urandom_range(1, 16);
                load_key(len);
                sent += len;
            end else if (pick < 35) begin
                send_item(MODE_KEY, BYTE_W'($urandom_range(255)), 1'b0);
                sent++;
            end else begin
                send_item(MODE_DATA, BYTE_W'($urandom_range(255)),
                          1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    // receiver: random back-pressure, plus one long hold on request
    initial begin : rx_side
        int unsigned held;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                for (held = 0; held < RX_HOLD_CYCLES; held++) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles 35%, receiver 66%
        send_idle_pct = 35;
        recv_idle_pct = 66;

        // data before any key runs on the identity permutation
        send_item(MODE_DATA, 8'h00, 1'b0);
        send_item(MODE_DATA, 8'hFF, 1'b1);
        send_item(MODE_DATA, 8'h5A, 1'b0);
        // one-byte key
        send_item(MODE_KEY,  8'hFF, 1'b1);
        send_item(MODE_DATA, 8'h00, 1'b0);
        send_item(MODE_DATA, 8'hFF, 1'b0);
        // five-byte key with the extreme byte values
        send_item(MODE_KEY,  8'h00, 1'b0);
        send_item(MODE_KEY,  8'h01, 1'b0);
        send_item(MODE_KEY,  8'h80, 1'b0);
        send_item(MODE_KEY,  8'hFF, 1'b0);
        send_item(MODE_KEY,  8'h7E, 1'b1);
        send_item(MODE_DATA, 8'h00, 1'b0);
        send_item(MODE_DATA, 8'hFF, 1'b1);
        send_item(MODE_DATA, 8'h3C, 1'b0);
        // single zero key byte
        send_item(MODE_KEY,  8'h00, 1'b1);
        send_item(MODE_DATA, 8'hA5, 1'b0);
        send_item(MODE_DATA, 8'h5A, 1'b0);
        // key split by a data byte, the store keeps counting
        send_item(MODE_KEY,  8'h12, 1'b0);
        send_item(MODE_DATA, 8'h99, 1'b0);
        send_item(MODE_KEY,  8'h34, 1'b1);
        send_item(MODE_DATA, 8'h00, 1'b0);
        send_item(MODE_DATA, 8'hFF, 1'b0);

        // past the store depth with the flag on a dropped byte, then exactly full
        load_key(258);
        send_item(MODE_DATA, 8'hC3, 1'b0);
        load_key(256);
        send_item(MODE_DATA, 8'h3C, 1'b0);

        random_traffic(380);
        drain_results();

        // sender idles 66%, receiver 35%
        send_idle_pct = 66;
        recv_idle_pct = 35;

        // long receiver hold while data keeps coming, input must stall
        rx_hold_req = 1'b1;
        repeat (12) send_item(MODE_DATA, BYTE_W'($urandom_range(255)), 1'b0);
        drain_results();

        random_traffic(380);

        // no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(380);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && outstanding_bytes == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
